[hdl/twspi_pkg.sv]
package twspi_pkg;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_SEND = 3'd1,
    PH_RECV = 3'd2,
    PH_TAIL = 3'd3,
    PH_GAP  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    OP_REG_WR  = 2'd0,
    OP_REG_RD  = 2'd1,
    OP_FIFO_WR = 2'd2,
    OP_FIFO_RD = 2'd3
  } op_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [1:0] CFG_FIFO_GAP    = 2'd1;
  localparam logic [1:0] CFG_REG_TAIL    = 2'd2;

  localparam logic [7:0] HALF_PERIOD_RST = 8'd1;
  localparam logic [7:0] FIFO_GAP_RST    = 8'd10;
  localparam logic [7:0] REG_TAIL_RST    = 8'd5;

  localparam logic [4:0] REG_WR_BITS = 5'd16;
  localparam logic [4:0] BYTE_BITS   = 5'd8;

  typedef struct packed {
    logic       start_req;
    logic [1:0] opcode;
    logic [6:0] reg_address;
    logic [7:0] write_byte;
    logic       sdio_in;
  } in_item_t;

  typedef struct packed {
    logic       reg_select_n;
    logic       fifo_select_n;
    logic       sclk;
    logic       sdio_out;
    logic       sdio_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
  } out_item_t;

  typedef struct packed {
    logic [7:0] half_period_ticks;
    logic [7:0] fifo_gap_ticks;
    logic [7:0] reg_tail_ticks;
  } cfg_t;

endpackage

[hdl/twspi_cfg.sv]
module twspi_cfg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [1:0]           wr_index_i,
  input  logic [7:0]           wr_data_i,
  output twspi_pkg::cfg_t      cfg_o
);

  twspi_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        twspi_pkg::CFG_HALF_PERIOD: cfg_d.half_period_ticks = wr_data_i;
        twspi_pkg::CFG_FIFO_GAP:    cfg_d.fifo_gap_ticks    = wr_data_i;
        twspi_pkg::CFG_REG_TAIL:    cfg_d.reg_tail_ticks    = wr_data_i;
        default:                    cfg_d                   = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period_ticks <= twspi_pkg::HALF_PERIOD_RST;
      cfg_q.fifo_gap_ticks    <= twspi_pkg::FIFO_GAP_RST;
      cfg_q.reg_tail_ticks    <= twspi_pkg::REG_TAIL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/twspi_core.sv]
module twspi_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  twspi_pkg::in_item_t   item_i,
  input  twspi_pkg::cfg_t       cfg_i,
  output twspi_pkg::out_item_t  res_o
);

  twspi_pkg::phase_e phase_q, phase_d;
  twspi_pkg::op_e    op_q, op_d;
  logic [4:0]        bits_q, bits_d;
  logic [15:0]       sout_q, sout_d;
  logic [7:0]        sin_q, sin_d;
  logic [7:0]        ticks_q, ticks_d;
  logic              lvl_q, lvl_d;

  logic [7:0] half;
  logic [7:0] len;
  logic       is_reg;
  logic       half_end;

  always_comb begin
    phase_d = phase_q;
    op_d    = op_q;
    bits_d  = bits_q;
    sout_d  = sout_q;
    sin_d   = sin_q;
    ticks_d = ticks_q;
    lvl_d   = lvl_q;
    res_o   = '0;
    res_o.reg_select_n  = 1'b1;
    res_o.fifo_select_n = 1'b1;
    res_o.sdio_drive    = 1'b1;
    half = (cfg_i.half_period_ticks == 8'd0) ? 8'd1 : cfg_i.half_period_ticks;
    len  = 8'd0;
    is_reg   = 1'b0;
    half_end = 1'b0;

    // Load the frame on a start seen while idle
    if (phase_q == twspi_pkg::PH_IDLE && item_i.start_req) begin
      op_d    = twspi_pkg::op_e'(item_i.opcode);
      ticks_d = 8'd0;
      lvl_d   = 1'b0;
      bits_d  = twspi_pkg::BYTE_BITS;
      phase_d = twspi_pkg::PH_SEND;
      case (twspi_pkg::op_e'(item_i.opcode))
        twspi_pkg::OP_REG_WR: begin
          sout_d = {1'b0, item_i.reg_address, item_i.write_byte};
          bits_d = twspi_pkg::REG_WR_BITS;
        end
        twspi_pkg::OP_REG_RD:  sout_d = {1'b1, item_i.reg_address, 8'h00};
        twspi_pkg::OP_FIFO_WR: sout_d = {item_i.write_byte, 8'h00};
        default: begin
          sout_d  = 16'h0000;
          phase_d = twspi_pkg::PH_RECV;
        end
      endcase
    end

    if (phase_d != twspi_pkg::PH_IDLE) begin
      is_reg = (op_d == twspi_pkg::OP_REG_WR) || (op_d == twspi_pkg::OP_REG_RD);
      res_o.busy_res = 1'b1;
      if (phase_d inside {twspi_pkg::PH_SEND, twspi_pkg::PH_RECV}) begin
        res_o.reg_select_n  = !is_reg;
        res_o.fifo_select_n = is_reg;
        res_o.sclk          = lvl_d;
        if (phase_d == twspi_pkg::PH_SEND) begin
          res_o.sdio_out = sout_d[15];
        end else begin
          res_o.sdio_drive = 1'b0;
        end
        half_end = ({1'b0, ticks_d} + 9'd1) >= {1'b0, half};
        if (!half_end) begin
          ticks_d = ticks_d + 8'd1;
        end else begin
          ticks_d = 8'd0;
          if (!lvl_d) begin
            lvl_d = 1'b1;
          end else begin
            lvl_d = 1'b0;
            if (phase_d == twspi_pkg::PH_RECV) begin
              sin_d = {sin_d[6:0], item_i.sdio_in};
            end
            sout_d = {sout_d[14:0], 1'b0};
            if (bits_d != 5'd0) begin
              bits_d = bits_d - 5'd1;
            end
            if (bits_d == 5'd0) begin
              if (phase_d == twspi_pkg::PH_SEND && op_d == twspi_pkg::OP_REG_RD) begin
                phase_d = twspi_pkg::PH_RECV;
                bits_d  = twspi_pkg::BYTE_BITS;
              end else begin
                case (op_d)
                  twspi_pkg::OP_REG_WR: len = cfg_i.reg_tail_ticks;
                  twspi_pkg::OP_REG_RD: len = 8'd0;
                  default:              len = cfg_i.fifo_gap_ticks;
                endcase
                if (len == 8'd0) begin
                  phase_d        = twspi_pkg::PH_IDLE;
                  res_o.done_res = 1'b1;
                end else if (op_d == twspi_pkg::OP_REG_WR) begin
                  phase_d = twspi_pkg::PH_TAIL;
                end else begin
                  phase_d = twspi_pkg::PH_GAP;
                end
              end
            end
          end
        end
      end else begin
        // Tail or gap: count idle ticks with sclk low
        if (phase_d == twspi_pkg::PH_TAIL) begin
          len = cfg_i.reg_tail_ticks;
          res_o.reg_select_n = 1'b0;
        end else begin
          len = cfg_i.fifo_gap_ticks;
          res_o.sdio_drive = (op_d == twspi_pkg::OP_FIFO_WR);
        end
        ticks_d = ticks_d + 8'd1;
        if (ticks_d >= len) begin
          phase_d        = twspi_pkg::PH_IDLE;
          ticks_d        = 8'd0;
          res_o.done_res = 1'b1;
        end
      end
    end
    res_o.read_byte = sin_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= twspi_pkg::PH_IDLE;
      op_q    <= twspi_pkg::OP_REG_WR;
      bits_q  <= 5'd0;
      sout_q  <= 16'h0000;
      sin_q   <= 8'h00;
      ticks_q <= 8'd0;
      lvl_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      op_q    <= op_d;
      bits_q  <= bits_d;
      sout_q  <= sout_d;
      sin_q   <= sin_d;
      ticks_q <= ticks_d;
      lvl_q   <= lvl_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.done_res |=> phase_q == twspi_pkg::PH_IDLE)
    else $error("done beat did not return the engine to idle");

  a_one_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |-> (res_o.reg_select_n || res_o.fifo_select_n))
    else $error("both selects low in one beat");

  a_release_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !res_o.sdio_drive |->
      (op_d == twspi_pkg::OP_REG_RD || op_d == twspi_pkg::OP_FIFO_RD))
    else $error("data pin released outside a read");

  a_idle_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !res_o.busy_res |->
      (res_o.reg_select_n && res_o.fifo_select_n && !res_o.sclk && res_o.sdio_drive))
    else $error("pins not at idle levels outside a transaction");
`endif

endmodule

[hdl/three_wire_spi_radio_master_unit.sv]
// Channel  Direction  Handshake                Payload
// in       sink       in_valid_i / in_ready_o   twspi_pkg::in_item_t  (one tick of pins)
// out      source     out_valid_o / out_ready_i twspi_pkg::out_item_t (pin levels, status)
// cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One beat in, one beat out: the tick engine updates its state and the result
// register in the same edge, so a beat is taken every cycle unless out stalls.
// The result register alone sets throughput; it is loaded whenever a beat
// arrives and it is empty or being drained in that cycle.
// A stall on out holds the result and drops in_ready_o; nothing is lost.
// Reset (rst_ni low, asynchronous) idles the engine, empties the result
// register and loads the configuration defaults. cfg is always ready.
module three_wire_spi_radio_master_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  twspi_pkg::in_item_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output twspi_pkg::out_item_t  out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [7:0]            cfg_data_i
);

  twspi_pkg::cfg_t      cfg;
  twspi_pkg::out_item_t res;
  twspi_pkg::out_item_t res_q;
  logic                 out_valid_q, out_valid_d;
  logic                 step;

  // Take a beat whenever the result slot is free or emptying this cycle
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign step        = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  twspi_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Advance the serial engine by one tick per accepted beat
  twspi_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_data_i),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload: load on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

  // Directed rows: a single tick repeated, a whole transfer, or a register load
  typedef enum logic [1:0] {
    ROW_TICK,
    ROW_XFER,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    twspi_pkg::in_item_t  item;
    int                   count;  // ROW_TICK: beats to send; ROW_XFER: nonzero holds start
    bit                   typed;  // compare the first beat with want instead of the predictor
    twspi_pkg::out_item_t want;
    twspi_pkg::cfg_t      cfg;
  } dir_row_t;

  localparam twspi_pkg::out_item_t NO_WANT = '0;
  localparam twspi_pkg::cfg_t      NO_CFG  = '0;
  localparam twspi_pkg::in_item_t  NO_ITEM = '0;
  localparam int                   RANDOM_ITEMS = 260;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  twspi_pkg::in_item_t  in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  twspi_pkg::out_item_t out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [1:0]           cfg_index_i = twspi_pkg::CFG_HALF_PERIOD;
  logic [7:0]           cfg_data_i = '0;

  three_wire_spi_radio_master_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow of the serial engine; starts in its reset state
  twspi_pkg::phase_e eng_phase = twspi_pkg::PH_IDLE;
  twspi_pkg::op_e    eng_op    = twspi_pkg::OP_REG_WR;
  logic [4:0]        eng_bits  = '0;
  logic [15:0]       eng_tx    = '0;
  logic [7:0]        eng_rx    = '0;
  logic [7:0]        eng_ticks = '0;
  logic              eng_sclk  = 1'b0;
  twspi_pkg::cfg_t   cfg_q     = '{twspi_pkg::HALF_PERIOD_RST, twspi_pkg::FIFO_GAP_RST,
                                   twspi_pkg::REG_TAIL_RST};

  twspi_pkg::out_item_t pin_levels_q[$];   // expected pin levels, oldest first
  int                   mismatch_cnt = 0;
  bit                   calm = 1'b0;       // no idling on either side while set
  int                   stall_left = 0;

  // Advance the shadow engine by one tick and return the pin levels of that tick.
  function automatic twspi_pkg::out_item_t spi_tick(input twspi_pkg::in_item_t it);
    twspi_pkg::out_item_t o;
    logic [8:0]           half;
    logic [7:0]           len;
    logic                 is_reg;
    o = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00};
    // a zero half period behaves as one tick
    half = (cfg_q.half_period_ticks == 8'd0) ? 9'd1 : {1'b0, cfg_q.half_period_ticks};
    // the start tick is already the first low tick of bit one
    if (eng_phase == twspi_pkg::PH_IDLE && it.start_req) begin
      eng_op    = twspi_pkg::op_e'(it.opcode);
      eng_ticks = '0;
      eng_sclk  = 1'b0;
      eng_bits  = twspi_pkg::BYTE_BITS;
      eng_phase = twspi_pkg::PH_SEND;
      case (eng_op)
        twspi_pkg::OP_REG_WR: begin
          eng_tx   = {1'b0, it.reg_address, it.write_byte};
          eng_bits = twspi_pkg::REG_WR_BITS;
        end
        twspi_pkg::OP_REG_RD:  eng_tx = {1'b1, it.reg_address, 8'h00};
        twspi_pkg::OP_FIFO_WR: eng_tx = {it.write_byte, 8'h00};
        default: begin
          eng_tx    = '0;
          eng_phase = twspi_pkg::PH_RECV;
        end
      endcase
    end
    if (eng_phase != twspi_pkg::PH_IDLE) begin
      is_reg = (eng_op == twspi_pkg::OP_REG_WR) || (eng_op == twspi_pkg::OP_REG_RD);
      o.busy_res = 1'b1;
      if (eng_phase == twspi_pkg::PH_SEND || eng_phase == twspi_pkg::PH_RECV) begin
        o.reg_select_n  = !is_reg;
        o.fifo_select_n = is_reg;
        o.sclk          = eng_sclk;
        if (eng_phase == twspi_pkg::PH_SEND) begin
          o.sdio_out = eng_tx[15];
        end else begin
          o.sdio_drive = 1'b0;
        end
        if ({1'b0, eng_ticks} + 9'd1 < half) begin
          eng_ticks = eng_ticks + 8'd1;
        end else begin
          eng_ticks = '0;
          if (!eng_sclk) begin
            eng_sclk = 1'b1;
          end else begin
            // end of a high half period: sample, shift, count the bit
            eng_sclk = 1'b0;
            if (eng_phase == twspi_pkg::PH_RECV) eng_rx = {eng_rx[6:0], it.sdio_in};
            eng_tx = eng_tx << 1;
            if (eng_bits != 5'd0) eng_bits = eng_bits - 5'd1;
            if (eng_bits == 5'd0) begin
              if (eng_phase == twspi_pkg::PH_SEND && eng_op == twspi_pkg::OP_REG_RD) begin
                eng_phase = twspi_pkg::PH_RECV;
                eng_bits  = twspi_pkg::BYTE_BITS;
              end else begin
                // register reads have no tail; a zero tail or gap ends right here
                len = (eng_op == twspi_pkg::OP_REG_WR) ? cfg_q.reg_tail_ticks :
                      (eng_op == twspi_pkg::OP_REG_RD) ? 8'd0 : cfg_q.fifo_gap_ticks;
                if (len == 8'd0) begin
                  eng_phase  = twspi_pkg::PH_IDLE;
                  o.done_res = 1'b1;
                end else begin
                  eng_phase = (eng_op == twspi_pkg::OP_REG_WR) ? twspi_pkg::PH_TAIL :
                                                                 twspi_pkg::PH_GAP;
                end
              end
            end
          end
        end
      end else begin
        len = (eng_phase == twspi_pkg::PH_TAIL) ? cfg_q.reg_tail_ticks :
                                                  cfg_q.fifo_gap_ticks;
        if (eng_phase == twspi_pkg::PH_TAIL) begin
          o.reg_select_n = 1'b0;
        end else begin
          o.sdio_drive = (eng_op == twspi_pkg::OP_FIFO_WR);
        end
        eng_ticks = eng_ticks + 8'd1;
        // a shortened length that the count already meets ends the phase
        if (eng_ticks >= len) begin
          eng_phase  = twspi_pkg::PH_IDLE;
          eng_ticks  = '0;
          o.done_res = 1'b1;
        end
      end
    end
    o.read_byte = eng_rx;
    return o;
  endfunction

  // Idle length: mostly none, often short, now and then long.
  function automatic int pick_wait();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Tail or gap length for random settings, zero and the far end included.
  function automatic logic [7:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'd0;
    if (r < 90) return 8'($urandom_range(1, 16));
    return 8'($urandom_range(200, 255));
  endfunction

  // Send one beat, after a random idle stretch, and log what it should produce.
  task automatic send_item(input twspi_pkg::in_item_t it, input bit typed,
                           input twspi_pkg::out_item_t want);
    int                   gap;
    twspi_pkg::out_item_t guess;
    gap = pick_wait();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // keep the shadow engine in step even where the result is typed in
    guess = spi_tick(it);
    pin_levels_q.push_back(typed ? want : guess);
  endtask

  // Drop valid and hold off until every outstanding beat has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pin_levels_q.size() != 0) @(posedge clk_i);
  endtask

  // Write all three registers back to back once the pipe is empty.
  task automatic load_cfg(input twspi_pkg::cfg_t c);
    logic [1:0] idx [3];
    logic [7:0] val [3];
    idx = '{twspi_pkg::CFG_HALF_PERIOD, twspi_pkg::CFG_FIFO_GAP, twspi_pkg::CFG_REG_TAIL};
    val = '{c.half_period_ticks, c.fifo_gap_ticks, c.reg_tail_ticks};
    drain_results();
    for (int k = 0; k < 3; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= val[k];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (idx[k])
        twspi_pkg::CFG_HALF_PERIOD: cfg_q.half_period_ticks = val[k];
        twspi_pkg::CFG_FIFO_GAP:    cfg_q.fifo_gap_ticks    = val[k];
        default:                    cfg_q.reg_tail_ticks    = val[k];
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Result side: stall at random, mostly single cycles with the odd long hold.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= pick_wait();
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic check_pin(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  // Compare every accepted result beat against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    twspi_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pin_levels_q.size() == 0) begin
        $display("%0t: result beat with nothing pending, expected none got %p",
                 $time, out_data_o);
        mismatch_cnt++;
      end else begin
        want = pin_levels_q.pop_front();
        check_pin("reg_select_n", 8'(want.reg_select_n), 8'(out_data_o.reg_select_n));
        check_pin("fifo_select_n", 8'(want.fifo_select_n), 8'(out_data_o.fifo_select_n));
        check_pin("sclk", 8'(want.sclk), 8'(out_data_o.sclk));
        check_pin("sdio_out", 8'(want.sdio_out), 8'(out_data_o.sdio_out));
        check_pin("sdio_drive", 8'(want.sdio_drive), 8'(out_data_o.sdio_drive));
        check_pin("busy_res", 8'(want.busy_res), 8'(out_data_o.busy_res));
        check_pin("done_res", 8'(want.done_res), 8'(out_data_o.done_res));
        check_pin("read_byte", want.read_byte, out_data_o.read_byte);
      end
    end
  end

  // Directed table. Typed pin levels are laid out as
  // {reg_sel_n, fifo_sel_n, sclk, sdio_out, sdio_drive, busy, done, read_byte}.
  dir_row_t dir_rows [21] = '{
    // idle pins straight out of reset
    '{ROW_TICK, '{1'b0, twspi_pkg::OP_REG_WR, 7'h00, 8'h00, 1'b0}, 2, 1'b1,
      '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00}, NO_CFG},
    // register write, all ones: address bit 7 still goes out low
    '{ROW_XFER, '{1'b1, twspi_pkg::OP_REG_WR, 7'h7f, 8'hff, 1'b1}, 0, 1'b1,
      '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00}, NO_CFG},
    '{ROW_XFER, '{1'b1, twspi_pkg::OP_REG_WR, 7'h00, 8'h00, 1'b0}, 0, 1'b0,
      NO_WANT, NO_CFG},
    // register read with the pin held high: address bit 7 set, byte reads ff
    '{ROW_XFER, '{1'b1, twspi_pkg::OP_REG_RD, 7'h00, 8'h00, 1'b1}, 0, 1'b1,
      '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00}, NO_CFG},
    // register read, pin low, start held high the whole way through
    '{ROW_XFER, '{1'b1, twspi_pkg::OP_REG_RD, 7'h7f, 8'hff, 1'b0}, 1, 1'b1,
      '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 8'hff}, NO_CFG},
    '{ROW_XFER, '{1'b1, twspi_pkg::OP_FIFO_WR, 7'h00, 8'ha5, 1'b0}, 0, 1'b1,
      '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00}, NO_CFG},
    '{ROW_XFER, '{1'b1, twspi_pkg::OP_FIFO_RD, 7'h00, 8'h00, 1'b1}, 0, 1'b1,
      '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00}, NO_CFG},
    // zero half period, no tail, no gap
    '{ROW_CFG, NO_ITEM, 0, 1'b0, NO_WANT, '{8'd0, 8'd0, 8'd0}},
    '{ROW_XFER, '{1'b1, twspi_pkg::OP_REG_WR, 7'h55, 8'haa, 1'b0}, 0, 1'b0,
      NO_WANT, NO_CFG},
    '{ROW_XFER, '{1'b1, twspi_pkg::OP_FIFO_WR, 7'h2a, 8'h5a, 1'b1}, 0, 1'b0,
      NO_WANT, NO_CFG},
    '{ROW_XFER, '{1'b1, twspi_pkg::OP_FIFO_RD, 7'h11, 8'h3c, 1'b1}, 0, 1'b0,
      NO_WANT, NO_CFG},
    // short tail, and a gap long enough to stop partway through
    '{ROW_CFG, NO_ITEM, 0, 1'b0, NO_WANT, '{8'd1, 8'd20, 8'd12}},
    '{ROW_XFER, '{1'b1, twspi_pkg::OP_REG_WR, 7'h2a, 8'h81, 1'b0}, 0, 1'b0,
      NO_WANT, NO_CFG},
    '{ROW_XFER, '{1'b1, twspi_pkg::OP_FIFO_RD, 7'h00, 8'h00, 1'b0}, 0, 1'b0,
      NO_WANT, NO_CFG},
    // stop a dozen ticks into the gap, then shorten it below the count
    '{ROW_TICK, '{1'b1, twspi_pkg::OP_FIFO_WR, 7'h00, 8'hc3, 1'b0}, 28, 1'b0,
      NO_WANT, NO_CFG},
    '{ROW_CFG, NO_ITEM, 0, 1'b0, NO_WANT, '{8'd1, 8'd4, 8'd12}},
    '{ROW_TICK, '{1'b0, twspi_pkg::OP_FIFO_WR, 7'h00, 8'h00, 1'b0}, 3, 1'b0,
      NO_WANT, NO_CFG},
    // longest half period: the whole low half of bit one and one high tick
    '{ROW_CFG, NO_ITEM, 0, 1'b0, NO_WANT, '{8'd255, 8'd1, 8'd0}},
    '{ROW_TICK, '{1'b1, twspi_pkg::OP_FIFO_WR, 7'h00, 8'h81, 1'b1}, 256, 1'b0,
      NO_WANT, NO_CFG},
    // shorten the half period below the count and run the byte out
    '{ROW_CFG, NO_ITEM, 0, 1'b0, NO_WANT, '{8'd1, 8'd1, 8'd0}},
    '{ROW_XFER, '{1'b0, twspi_pkg::OP_FIFO_WR, 7'h00, 8'h00, 1'b1}, 0, 1'b0,
      NO_WANT, NO_CFG}
  };

  initial begin
    dir_row_t            row;
    twspi_pkg::in_item_t it;
    twspi_pkg::cfg_t     c;
    int                  n;
    int                  random_items;
    random_items = 0;

    // hold reset, then release it on an edge
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // walk the directed table
    foreach (dir_rows[r]) begin
      row = dir_rows[r];
      case (row.kind)
        ROW_CFG: load_cfg(row.cfg);
        ROW_TICK: begin
          for (int k = 0; k < row.count; k++) begin
            it = row.item;
            if (k != 0) it.start_req = 1'b0;
            send_item(it, row.typed && k == 0, row.want);
          end
        end
        default: begin
          send_item(row.item, row.typed, row.want);
          // run the transfer out; start stays high only where the row asks
          it = row.item;
          it.start_req = (row.count != 0);
          while (eng_phase != twspi_pkg::PH_IDLE) send_item(it, 1'b0, NO_WANT);
        end
      endcase
    end

    // random phases: new settings, then mostly back-to-back transfers with
    // random content, stray starts while busy and idle ticks in between
    while (random_items < RANDOM_ITEMS) begin
      n = $urandom_range(0, 99);
      c.half_period_ticks = (n < 5)  ? 8'd0 :
                            (n < 80) ? 8'($urandom_range(1, 3)) : 8'($urandom_range(4, 12));
      c.fifo_gap_ticks = pick_len();
      c.reg_tail_ticks = pick_len();
      calm = ($urandom_range(0, 3) == 0);
      load_cfg(c);
      n = $urandom_range(20, 80);
      for (int k = 0; k < n || eng_phase != twspi_pkg::PH_IDLE; k++) begin
        it.opcode      = 2'($urandom_range(0, 3));
        it.reg_address = 7'($urandom);
        it.write_byte  = 8'($urandom);
        it.sdio_in     = 1'($urandom);
        it.start_req   = (eng_phase == twspi_pkg::PH_IDLE) ? ($urandom_range(0, 3) != 0) :
                                                             ($urandom_range(0, 3) == 0);
        send_item(it, 1'b0, NO_WANT);
        random_items++;
      end
    end

    // wait out the last results, then keep watching for strays
    calm = 1'b0;
    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[files.f]
hdl/twspi_pkg.sv
hdl/twspi_cfg.sv
hdl/twspi_core.sv
hdl/three_wire_spi_radio_master_unit.sv
tb/tb.sv
